[hdl/nghr_pkg.sv]
// Package: constants, types and register codes of the n-gram hash row addresser.
`default_nettype none
package nghr_pkg;

	localparam int NGRAM_ORDER     = 3;
	localparam int HEADS_PER_ORDER = 8;
	localparam int NUM_ORDERS      = NGRAM_ORDER - 1;
	localparam int PAST_DEPTH      = NGRAM_ORDER - 1;
	localparam int TABLE_DEPTH     = 16;
	localparam int TOTAL_HEADS     = (NUM_ORDERS * HEADS_PER_ORDER > TABLE_DEPTH) ?
		TABLE_DEPTH : NUM_ORDERS * HEADS_PER_ORDER;
	localparam int NUM_MULT        = 3;
	localparam int Q_DEPTH         = 2;

	localparam int TOK_W  = 32;
	localparam int MULT_W = 63;
	localparam int HASH_W = 64;
	localparam int MOD_W  = 32;
	localparam int OFF_W  = 40;
	localparam int ROW_W  = 41;
	localparam int HEAD_W = 4;
	localparam int CFG_W  = 63;
	localparam int IDX_W  = 2;

	// remainder unit: quotient bits per cycle and cycles per 64-bit dividend
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = HASH_W / DIV_BITS;
	localparam int DIV_CW     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	localparam int JW = (NGRAM_ORDER > 1) ? $clog2(NGRAM_ORDER) : 1;
	localparam int PW = (PAST_DEPTH > 1) ? $clog2(PAST_DEPTH) : 1;
	localparam int OW = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
	localparam int GW = (HEADS_PER_ORDER > 1) ? $clog2(HEADS_PER_ORDER) : 1;
	localparam int QW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_END_TOKEN = 2'd0,
		REG_MULT_0    = 2'd1,
		REG_MULT_1    = 2'd2,
		REG_MULT_2    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {F_IDLE, F_LOAD, F_MLO, F_MHI, F_ACC} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_START, B_DIV, B_OUT} back_state_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [OW-1:0]     ord;
	} q_entry_t;

	typedef struct packed {
		logic              en;
		logic [HEAD_W-1:0] sel;
		logic [MOD_W-1:0]  modulus;
		logic [OFF_W-1:0]  offset;
	} tbl_wr_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

endpackage
`default_nettype wire

[hdl/nghr_queue.sv]
// Module: short request queue between the hash front end and the row back end.
`default_nettype none
module nghr_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire nghr_pkg::q_entry_t wr_data,
	input  wire logic              rd_en,
	output nghr_pkg::q_entry_t     rd_data,
	output logic                   q_full,
	output logic                   q_empty
);
	nghr_pkg::q_entry_t                mem_q [nghr_pkg::Q_DEPTH];
	logic [nghr_pkg::QW-1:0]           wptr_q, rptr_q;
	logic [nghr_pkg::QCW-1:0]          cnt_q;

	assign q_full  = (cnt_q == nghr_pkg::QCW'(nghr_pkg::Q_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == nghr_pkg::QW'(nghr_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == nghr_pkg::QW'(nghr_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + nghr_pkg::QCW'(wr_en) - nghr_pkg::QCW'(rd_en);
		end
	end
endmodule
`default_nettype wire

[hdl/nghr_front.sv]
// Module: front end; accepts items, loads head entries and builds per-order hashes.
`default_nettype none
module nghr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          cmd,
	input  wire logic [nghr_pkg::TOK_W-1:0]    token,
	input  wire logic [nghr_pkg::HEAD_W-1:0]   head_sel,
	input  wire logic [nghr_pkg::MOD_W-1:0]    modulus,
	input  wire logic [nghr_pkg::OFF_W-1:0]    offset,
	input  wire logic                          cfg_wr_en,
	input  wire logic [nghr_pkg::IDX_W-1:0]    cfg_idx,
	input  wire logic [nghr_pkg::CFG_W-1:0]    cfg_data,
	input  wire nghr_pkg::back_stat_t          back_stat,
	input  wire logic                          q_full,
	output logic                               q_wr,
	output nghr_pkg::q_entry_t                 q_data,
	output nghr_pkg::tbl_wr_t                  tbl_wr
);
	nghr_pkg::front_state_t              state_q, state_d;
	logic [nghr_pkg::TOK_W-1:0]          tok_q, end_tok_q, win;
	logic [nghr_pkg::HEAD_W-1:0]         sel_q;
	logic [nghr_pkg::MOD_W-1:0]          mod_q;
	logic [nghr_pkg::OFF_W-1:0]          off_q;
	logic [nghr_pkg::JW-1:0]             j_q;
	logic [nghr_pkg::HASH_W-1:0]         hash_q, prod_s1, lo_q, term;
	logic [nghr_pkg::MULT_W-1:0]         mult_q [nghr_pkg::NUM_MULT];
	logic [nghr_pkg::MULT_W-1:0]         mult_sel;
	logic [nghr_pkg::TOK_W-1:0]          past_tok_q [nghr_pkg::PAST_DEPTH];
	logic [nghr_pkg::PAST_DEPTH-1:0]     past_live_q;
	logic [nghr_pkg::PW-1:0]             pidx;
	logic                                accept, need_push, last_slot;

	assign accept    = push && !full;
	assign full      = (state_q != nghr_pkg::F_IDLE);
	assign pidx      = nghr_pkg::PW'(j_q - 1'b1);
	assign last_slot = (j_q == nghr_pkg::JW'(nghr_pkg::NGRAM_ORDER - 1));
	// orders whose first head falls past the table are not sent
	assign need_push = (j_q != '0) &&
		((int'(j_q) - 1) * nghr_pkg::HEADS_PER_ORDER < nghr_pkg::TOTAL_HEADS);
	assign term      = lo_q + {prod_s1[31:0], 32'd0};

	always_comb begin
		if (j_q == '0) begin
			win = tok_q;
		end else if (past_live_q[pidx]) begin
			win = past_tok_q[pidx];
		end else begin
			win = end_tok_q;
		end
		mult_sel = nghr_pkg::MULT_W'(1);
		for (int k = 0; k < nghr_pkg::NUM_MULT; k++) begin
			if (k < nghr_pkg::NGRAM_ORDER && j_q == nghr_pkg::JW'(k)) begin
				mult_sel = mult_q[k];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_wr    = 1'b0;
		q_data.hash = hash_q ^ term;
		q_data.ord  = nghr_pkg::OW'(j_q - 1'b1);
		tbl_wr.en      = 1'b0;
		tbl_wr.sel     = sel_q;
		tbl_wr.modulus = mod_q;
		tbl_wr.offset  = off_q;
		unique case (state_q)
			nghr_pkg::F_IDLE: begin
				if (accept) begin
					state_d = cmd ? nghr_pkg::F_LOAD : nghr_pkg::F_MLO;
				end
			end
			nghr_pkg::F_LOAD: begin
				if (back_stat.idle) begin
					tbl_wr.en = 1'b1;
					state_d   = nghr_pkg::F_IDLE;
				end
			end
			nghr_pkg::F_MLO: state_d = nghr_pkg::F_MHI;
			nghr_pkg::F_MHI: state_d = nghr_pkg::F_ACC;
			nghr_pkg::F_ACC: begin
				if (!(need_push && q_full)) begin
					q_wr    = need_push;
					state_d = last_slot ? nghr_pkg::F_IDLE : nghr_pkg::F_MLO;
				end
			end
			default: state_d = nghr_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nghr_pkg::F_IDLE;
			end_tok_q   <= '0;
			past_live_q <= '0;
			for (int k = 0; k < nghr_pkg::NUM_MULT; k++) begin
				mult_q[k] <= nghr_pkg::MULT_W'(1);
			end
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (nghr_pkg::reg_idx_t'(cfg_idx))
					nghr_pkg::REG_END_TOKEN: end_tok_q <= cfg_data[nghr_pkg::TOK_W-1:0];
					nghr_pkg::REG_MULT_0:    mult_q[0] <= cfg_data;
					nghr_pkg::REG_MULT_1:    mult_q[1] <= cfg_data;
					nghr_pkg::REG_MULT_2:    mult_q[2] <= cfg_data;
					default: ;
				endcase
			end
			// advance the history once the last slot is hashed; an end token drops it
			if (state_q == nghr_pkg::F_ACC && state_d == nghr_pkg::F_IDLE) begin
				if (tok_q == end_tok_q) begin
					past_live_q <= '0;
				end else begin
					for (int k = nghr_pkg::PAST_DEPTH - 1; k > 0; k--) begin
						past_live_q[k] <= past_live_q[k-1];
					end
					past_live_q[0] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q  <= token;
			sel_q  <= head_sel;
			mod_q  <= modulus;
			off_q  <= offset;
			j_q    <= '0;
			hash_q <= '0;
		end
		if (state_q == nghr_pkg::F_MLO) begin
			prod_s1 <= {32'd0, win} * {32'd0, mult_sel[31:0]};
		end
		if (state_q == nghr_pkg::F_MHI) begin
			lo_q    <= prod_s1;
			prod_s1 <= {32'd0, win} * {33'd0, mult_sel[62:32]};
		end
		if (state_q == nghr_pkg::F_ACC && !(need_push && q_full)) begin
			hash_q <= hash_q ^ term;
			j_q    <= j_q + 1'b1;
			if (last_slot) begin
				for (int k = nghr_pkg::PAST_DEPTH - 1; k > 0; k--) begin
					past_tok_q[k] <= past_tok_q[k-1];
				end
				past_tok_q[0] <= tok_q;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/nghr_back.sv]
// Module: back end; head tables, iterative 64-by-32 remainder and result register.
`default_nettype none
module nghr_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire nghr_pkg::tbl_wr_t             tbl_wr,
	input  wire logic                          q_empty,
	input  wire nghr_pkg::q_entry_t            q_data,
	output logic                               q_rd,
	output nghr_pkg::back_stat_t               back_stat,
	output logic                               out_valid,
	input  wire logic                          pop,
	output logic [nghr_pkg::ROW_W-1:0]         row,
	output logic [nghr_pkg::HEAD_W-1:0]        head,
	output logic                               last
);
	nghr_pkg::back_state_t               state_q, state_d;
	logic [nghr_pkg::MOD_W-1:0]          mod_tab [nghr_pkg::TABLE_DEPTH];
	logic [nghr_pkg::OFF_W-1:0]          off_tab [nghr_pkg::TABLE_DEPTH];
	logic [nghr_pkg::HASH_W-1:0]         ent_hash_q, div_q, div_d;
	logic [nghr_pkg::OW-1:0]             ord_q;
	logic [nghr_pkg::GW-1:0]             g_q;
	logic [nghr_pkg::MOD_W-1:0]          dmod_q, rem_q, rem_fin;
	logic [nghr_pkg::MOD_W:0]            rem_d;
	logic [nghr_pkg::OFF_W-1:0]          doff_q;
	logic [nghr_pkg::DIV_CW-1:0]         cnt_q;
	logic [nghr_pkg::HEAD_W-1:0]         h;
	logic                                h_last, ord_done, out_wr, out_valid_q, div_end;

	assign h = nghr_pkg::HEAD_W'(int'(ord_q) * nghr_pkg::HEADS_PER_ORDER + int'(g_q));
	assign h_last   = (h == nghr_pkg::HEAD_W'(nghr_pkg::TOTAL_HEADS - 1));
	assign ord_done = h_last || (g_q == nghr_pkg::GW'(nghr_pkg::HEADS_PER_ORDER - 1));
	assign back_stat.idle = (state_q == nghr_pkg::B_IDLE) && q_empty;
	assign out_valid = out_valid_q;
	assign rem_fin  = (dmod_q == '0) ? '0 : rem_q;
	assign div_end  = (cnt_q == nghr_pkg::DIV_CW'(nghr_pkg::DIV_CYCLES - 1));

	// restoring division, four quotient bits a cycle
	always_comb begin
		rem_d = {1'b0, rem_q};
		div_d = div_q;
		for (int k = 0; k < nghr_pkg::DIV_BITS; k++) begin
			rem_d = {rem_d[nghr_pkg::MOD_W-1:0], div_d[nghr_pkg::HASH_W-1]};
			div_d = {div_d[nghr_pkg::HASH_W-2:0], 1'b0};
			if (rem_d >= {1'b0, dmod_q}) begin
				rem_d = rem_d - {1'b0, dmod_q};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_rd    = 1'b0;
		out_wr  = 1'b0;
		unique case (state_q)
			nghr_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_rd    = 1'b1;
					state_d = nghr_pkg::B_START;
				end
			end
			nghr_pkg::B_START: state_d = nghr_pkg::B_DIV;
			nghr_pkg::B_DIV: begin
				if (div_end) begin
					state_d = nghr_pkg::B_OUT;
				end
			end
			nghr_pkg::B_OUT: begin
				if (!out_valid_q || pop) begin
					out_wr  = 1'b1;
					state_d = ord_done ? nghr_pkg::B_IDLE : nghr_pkg::B_START;
				end
			end
			default: state_d = nghr_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nghr_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_wr) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr.en) begin
			mod_tab[tbl_wr.sel] <= tbl_wr.modulus;
			off_tab[tbl_wr.sel] <= tbl_wr.offset;
		end
		if (q_rd) begin
			ent_hash_q <= q_data.hash;
			ord_q      <= q_data.ord;
			g_q        <= '0;
		end
		if (state_q == nghr_pkg::B_START) begin
			div_q  <= ent_hash_q;
			rem_q  <= '0;
			cnt_q  <= '0;
			dmod_q <= mod_tab[h];
			doff_q <= off_tab[h];
		end
		if (state_q == nghr_pkg::B_DIV) begin
			div_q <= div_d;
			rem_q <= rem_d[nghr_pkg::MOD_W-1:0];
			cnt_q <= cnt_q + 1'b1;
		end
		if (out_wr) begin
			row  <= {9'd0, rem_fin} + {1'b0, doff_q};
			head <= h;
			last <= h_last;
			g_q  <= g_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> (!out_valid_q || pop))
		else $error("result register overwritten");
	a_tbl_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (state_q == nghr_pkg::B_IDLE && q_empty))
		else $error("head table written while rows pending");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nghr_pkg::B_DIV && dmod_q != '0) |-> (rem_q < dmod_q))
		else $error("partial remainder out of range");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nghr_pkg::B_OUT && $past(state_q) == nghr_pkg::B_DIV) |->
		$past(div_end))
		else $error("remainder finished early");
`endif
endmodule
`default_nettype wire

[hdl/ngram_hash_row_addresser.sv]
// Top level: n-gram hash row addresser (front end, request queue, back end).
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | push / full        | cmd, token, head_sel, modulus, offset
//  result    | pop / empty        | row, head, last
//  config    | cfg_wr_en          | cfg_idx, cfg_data (end token, multipliers)
//
// A token request passes each window slot through the front end's multiply-low,
// multiply-high and accumulate states (one 32x32 multiplier used twice per slot).
// Each back-end head row takes a table read, the 4-bit-per-cycle remainder unit's
// division steps and a result write. A head-entry load waits until the back end
// has drained all queued rows. Reset clears control and history liveness, zeroes
// the end token and sets the multipliers to one; tables need loading.
`default_nettype none
module ngram_hash_row_addresser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          cmd,
	input  wire logic [nghr_pkg::TOK_W-1:0]    token,
	input  wire logic [nghr_pkg::HEAD_W-1:0]   head_sel,
	input  wire logic [nghr_pkg::MOD_W-1:0]    modulus,
	input  wire logic [nghr_pkg::OFF_W-1:0]    offset,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [nghr_pkg::ROW_W-1:0]         row,
	output logic [nghr_pkg::HEAD_W-1:0]        head,
	output logic                               last,
	input  wire logic                          cfg_wr_en,
	input  wire logic [nghr_pkg::IDX_W-1:0]    cfg_idx,
	input  wire logic [nghr_pkg::CFG_W-1:0]    cfg_data
);
	nghr_pkg::q_entry_t    q_wdata, q_rdata;
	nghr_pkg::tbl_wr_t     tbl_wr;
	nghr_pkg::back_stat_t  back_stat;
	logic                  q_wr, q_rd, q_full, q_empty, out_valid;

	// hash requests flow front -> queue -> back; results leave via the back register
	nghr_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .token, .head_sel, .modulus, .offset,
		.cfg_wr_en, .cfg_idx, .cfg_data, .back_stat, .q_full,
		.q_wr, .q_data(q_wdata), .tbl_wr
	);

	nghr_queue u_queue (
		.clk, .arst_n, .wr_en(q_wr), .wr_data(q_wdata), .rd_en(q_rd),
		.rd_data(q_rdata), .q_full, .q_empty
	);

	nghr_back u_back (
		.clk, .arst_n, .tbl_wr, .q_empty, .q_data(q_rdata), .q_rd, .back_stat,
		.out_valid, .pop, .row, .head, .last
	);

	assign empty = !out_valid;
endmodule
`default_nettype wire

[dv/tb_ngram_hash_row_addresser.sv]
// Testbench: checks the n-gram hash row addresser against a behavioral predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_ngram_hash_row_addresser;
	import nghr_pkg::*;

	// Predicted row result: one per head of each token request.
	typedef struct {
		logic [ROW_W-1:0]  row;
		logic [HEAD_W-1:0] head;
		logic              last;
	} row_exp_t;

	// Scoreboard: holds the predictor state and the queue of expected rows.
	class row_scoreboard;
		logic [TOK_W-1:0]  end_tok;
		logic [MULT_W-1:0] mults [NUM_MULT];
		logic [TOK_W-1:0]  hist_tok [PAST_DEPTH];
		logic              hist_live [PAST_DEPTH];
		logic [MOD_W-1:0]  mod_tbl [TABLE_DEPTH];
		logic [OFF_W-1:0]  off_tbl [TABLE_DEPTH];
		row_exp_t          pending_rows [$];
		int                errors;

		function void clear();
			end_tok = '0;
			for (int i = 0; i < NUM_MULT; i++)
				mults[i] = MULT_W'(1);
			for (int i = 0; i < PAST_DEPTH; i++) begin
				hist_tok[i] = '0;
				hist_live[i] = 1'b0;
			end
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				mod_tbl[i] = '0;
				off_tbl[i] = '0;
			end
			pending_rows.delete();
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_END_TOKEN: end_tok = val[TOK_W-1:0];
				REG_MULT_0: mults[0] = val;
				REG_MULT_1: mults[1] = val;
				default: mults[2] = val;
			endcase
		endfunction

		// Note one accepted request and queue the rows it produces.
		function void note_request(logic c, logic [TOK_W-1:0] tok, logic [HEAD_W-1:0] sel,
				logic [MOD_W-1:0] m, logic [OFF_W-1:0] o);
			logic [63:0] win [NGRAM_ORDER];
			logic [63:0] hash, rem;
			row_exp_t    e;
			int          h;
			if (c) begin
				mod_tbl[sel] = m;
				off_tbl[sel] = o;
				return;
			end
			win[0] = {32'd0, tok};
			for (int j = 1; j < NGRAM_ORDER; j++)
				win[j] = {32'd0, hist_live[j-1] ? hist_tok[j-1] : end_tok};
			for (int n = 2; n <= NGRAM_ORDER; n++) begin
				hash = '0;
				for (int j = 0; j < n; j++)
					hash ^= win[j] * ((j < NUM_MULT) ? {1'b0, mults[j]} : 64'd1);
				for (int g = 0; g < HEADS_PER_ORDER; g++) begin
					h = (n - 2) * HEADS_PER_ORDER + g;
					if (h < TOTAL_HEADS) begin
						rem = (mod_tbl[h] != 0) ? hash % {32'd0, mod_tbl[h]} : 64'd0;
						e.row = rem[ROW_W-1:0] + {1'b0, off_tbl[h]};
						e.head = h[HEAD_W-1:0];
						e.last = (h == TOTAL_HEADS - 1);
						pending_rows.push_back(e);
					end
				end
			end
			for (int j = PAST_DEPTH - 1; j > 0; j--) begin
				hist_tok[j] = hist_tok[j-1];
				hist_live[j] = hist_live[j-1];
			end
			hist_tok[0] = tok;
			hist_live[0] = 1'b1;
			if (tok == end_tok)
				for (int j = 0; j < PAST_DEPTH; j++)
					hist_live[j] = 1'b0;
		endfunction

		// Compare one accepted row with the oldest expectation.
		function void check_row(logic [ROW_W-1:0] r, logic [HEAD_W-1:0] hd, logic l);
			row_exp_t e;
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected row: row=%h head=%0d last=%0b", $time, r, hd, l);
				errors++;
				return;
			end
			e = pending_rows.pop_front();
			if (e.row !== r) begin
				$display("%0t: row mismatch: expected %h actual %h", $time, e.row, r);
				errors++;
			end
			if (e.head !== hd) begin
				$display("%0t: head mismatch: expected %0d actual %0d", $time, e.head, hd);
				errors++;
			end
			if (e.last !== l) begin
				$display("%0t: last mismatch: expected %0b actual %0b", $time, e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic               cmd = 1'b0;
	logic [TOK_W-1:0]   token = '0;
	logic [HEAD_W-1:0]  head_sel = '0;
	logic [MOD_W-1:0]   modulus = '0;
	logic [OFF_W-1:0]   offset = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [ROW_W-1:0]   row;
	logic [HEAD_W-1:0]  head;
	logic               last;
	logic               cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]   cfg_idx = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	row_scoreboard sb = new();
	int  send_idle_pct = 0;   // percent of cycles the sender idles
	int  recv_stall_pct = 0;  // percent of cycles the receiver stalls
	int  hold_off = 0;        // cycles left in a long receiver hold-off
	longint cycles = 0;
	logic [TOK_W-1:0] recent_toks [8];

	ngram_hash_row_addresser u_top (.*);

	always #1 clk = ~clk;

	// Watchdog: reports a failure and stops if the run goes on too long.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: sample at the rising edge, decide pop at the falling edge.
	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_row(row, head, last);

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			pop <= 1'b0;
		end else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Send one request; push stays high into the next request unless the sender idles.
	task automatic send_request(logic c, logic [TOK_W-1:0] tok, logic [HEAD_W-1:0] sel,
			logic [MOD_W-1:0] m, logic [OFF_W-1:0] o);
		cfg_wr_en <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		token <= tok;
		head_sel <= sel;
		modulus <= m;
		offset <= o;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(c, tok, sel, m, o);
		@(negedge clk);
	endtask

	// Wait until every expected row has come, then let the back end settle.
	task automatic drain();
		push <= 1'b0;
		while (sb.pending_rows.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Modulus spread: tiny, full-range, and zero (row equals offset).
	function automatic logic [MOD_W-1:0] pick_modulus();
		case ($urandom_range(4))
			0: return $urandom_range(7);
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	task automatic load_heads();
		for (int h = 0; h < TABLE_DEPTH; h++)
			send_request(1'b1, $urandom(), HEAD_W'(h), pick_modulus(), OFF_W'(rand64()));
	endtask

	// Token choice: some end tokens, small values and recent repeats, otherwise random.
	function automatic logic [TOK_W-1:0] pick_token();
		case ($urandom_range(9))
			0: return sb.end_tok;
			1: return $urandom_range(3);
			2: return recent_toks[3'($urandom_range(7))];
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		logic [TOK_W-1:0] t;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(15) == 0)
				send_request(1'b1, $urandom(), HEAD_W'($urandom_range(15)), pick_modulus(),
					OFF_W'(rand64()));
			else begin
				t = pick_token();
				recent_toks[3'($urandom_range(7))] = t;
				send_request(1'b0, t, HEAD_W'($urandom()), $urandom(), OFF_W'(rand64()));
			end
		end
		drain();
	endtask

	initial begin
		sb.clear();
		for (int i = 0; i < 8; i++)
			recent_toks[i] = $urandom();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extreme table entries, zero modulus, end tokens, default registers.
		send_request(1'b1, '1, 4'd0, 32'd0, '1);
		send_request(1'b1, '0, 4'd15, 32'hFFFF_FFFF, '1);
		for (int h = 1; h < 15; h++)
			send_request(1'b1, '0, HEAD_W'(h), (h == 1) ? 32'd1 : $urandom(), h[0] ? '0 : '1);
		send_request(1'b0, 32'hFFFF_FFFF, '1, '1, '1);
		send_request(1'b0, 32'd0, '0, '0, '0);   // end token clears history
		send_request(1'b0, 32'h1234_5678, '0, '0, '0);
		send_request(1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		drain();

		// Extreme register values: all-ones end token and multiplier, a zero and an even one.
		write_reg(REG_END_TOKEN, 63'hFFFF_FFFF);
		write_reg(REG_MULT_0, '1);
		write_reg(REG_MULT_1, 63'd0);
		write_reg(REG_MULT_2, 63'd2);
		send_request(1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		send_request(1'b0, 32'h8000_0000, '0, '0, '0);
		send_request(1'b0, 32'd7, '0, '0, '0);
		send_request(1'b0, 32'hFFFF_FFFF, '0, '0, '0);
		drain();

		// Random: no idling, with a long receiver hold-off to fill the block.
		write_reg(REG_END_TOKEN, CFG_W'($urandom_range(3)));
		write_reg(REG_MULT_0, CFG_W'(rand64() | 64'd1));
		write_reg(REG_MULT_1, CFG_W'(rand64() | 64'd1));
		write_reg(REG_MULT_2, CFG_W'(rand64() | 64'd1));
		load_heads();
		hold_off = 3000;
		random_phase(32, 0, 0);

		write_reg(REG_MULT_0, CFG_W'(rand64()));
		write_reg(REG_MULT_2, 63'd1);
		random_phase(32, 64, 0);

		write_reg(REG_END_TOKEN, CFG_W'($urandom()));
		write_reg(REG_MULT_1, '1);
		load_heads();
		random_phase(32, 0, 64);

		write_reg(REG_END_TOKEN, 63'd0);
		write_reg(REG_MULT_0, 63'd1);
		random_phase(32, 7, 7);

		if (sb.errors == 0 && sb.pending_rows.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
hdl/nghr_pkg.sv
hdl/nghr_queue.sv
hdl/nghr_front.sv
hdl/nghr_back.sv
hdl/ngram_hash_row_addresser.sv
dv/tb_ngram_hash_row_addresser.sv
